// ----- rtl/itmh_pkg.sv -----
`default_nettype none
package itmh_pkg;
  localparam int unsigned CapacityDefault = 64;
  localparam int unsigned IdCountDefault = 64;
  localparam int unsigned IdW = 6;
  localparam int unsigned KeyW = 64;
  localparam int unsigned KindW = 2;
  localparam int unsigned StatusW = 3;
  localparam int unsigned CountW = 7;

  localparam logic [KindW-1:0] KIND_INSERT = 2'd0;
  localparam logic [KindW-1:0] KIND_POP = 2'd1;
  localparam logic [KindW-1:0] KIND_REMOVE = 2'd2;
  // Unused kind: changes nothing and reports the front and count.
  localparam logic [KindW-1:0] KIND_NONE = 2'd3;

  localparam logic [StatusW-1:0] ST_OK = 3'd0;
  localparam logic [StatusW-1:0] ST_ABSENT = 3'd1;
  localparam logic [StatusW-1:0] ST_EMPTY = 3'd2;
  localparam logic [StatusW-1:0] ST_FULL = 3'd3;
  localparam logic [StatusW-1:0] ST_PRESENT = 3'd4;

  // One request as it leaves the front queue.
  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [IdW-1:0]   item_id;
    logic [KeyW-1:0]  wakeup_time;
  } req_t;

  // One result as it enters the result queue.
  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [IdW-1:0]     popped_id;
    logic [KeyW-1:0]    popped_time;
    logic               front_valid;
    logic [IdW-1:0]     front_id;
    logic [KeyW-1:0]    front_time;
    logic [CountW-1:0]  entry_count;
  } rsp_t;
endpackage
`default_nettype wire

// ----- rtl/itmh_fifo.sv -----
`default_nettype none
module itmh_fifo import itmh_pkg::*; #(
  parameter int unsigned Width = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [Width-1:0]      data_o,
  output logic                  empty_o
);
  // Two-entry queue; each side stalls on its own.
  logic [Width-1:0] mem_q [2];
  logic             wptr_q, rptr_q;
  logic [1:0]       cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (do_push) wptr_q <= ~wptr_q;
      if (do_pop) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= data_i;
  end
endmodule
`default_nettype wire

// ----- rtl/itmh_core.sv -----
`default_nettype none
module itmh_core import itmh_pkg::*; #(
  parameter int unsigned Capacity = CapacityDefault,
  parameter int unsigned IdCount = IdCountDefault
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic req_valid_i,
  input  wire req_t req_i,
  output logic      req_ready_o,
  output logic      rsp_valid_o,
  output rsp_t      rsp_o,
  input  wire logic rsp_ready_i
);
  localparam int unsigned SlotW = $clog2(Capacity);
  localparam int unsigned SizeW = $clog2(Capacity + 1);
  localparam int unsigned IdxW = (IdCount > 1) ? $clog2(IdCount) : 1;
  localparam logic [SizeW-1:0] CapSize = SizeW'(Capacity);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_LAST  = 10'b0000000010,
    S_UPRD  = 10'b0000000100,
    S_UPCMP = 10'b0000001000,
    S_DNRD  = 10'b0000010000,
    S_DNL   = 10'b0000100000,
    S_DNCMP = 10'b0001000000,
    S_ROOT  = 10'b0010000000,
    S_FRONT = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_e;

  state_e state_q;

  // Heap storage: keys and ids in one memory, position table in another.
  logic [KeyW+IdW-1:0] heap_mem [Capacity];
  logic [SlotW-1:0]    pos_mem [IdCount];
  logic [IdCount-1:0]  idv_q;

  logic [SizeW-1:0] size_q;
  req_t             req_q;
  logic [SlotW-1:0] slot_q;
  logic [KeyW-1:0]  key_q;
  logic [IdW-1:0]   id_q;
  logic             moved_q;
  logic [KeyW+IdW-1:0] rd_q, cl_q;
  logic [SlotW-1:0] pos_rd_q;
  rsp_t             rsp_q;
  logic             rsp_v_q;

  // Memory port controls.
  logic             hw_en;
  logic [SlotW-1:0] hw_addr;
  logic [KeyW+IdW-1:0] hw_data;
  logic [SlotW-1:0] hr_addr;
  logic             pw_en;
  logic [IdxW-1:0]  pw_addr;
  logic [SlotW-1:0] pw_data;

  logic [IdxW-1:0]    req_idx;
  logic               id_ok;
  logic [StatusW-1:0] acc_status;
  logic [SlotW:0]     lchild, rchild;
  logic [SlotW-1:0]   parent;
  logic               up_move;
  logic               has_left, pick_right, dn_move;
  logic [KeyW+IdW-1:0] dn_elem;
  logic [SlotW-1:0]   dn_slot;

  assign req_idx = IdxW'(req_i.item_id);
  assign id_ok = (32'(req_i.item_id) < IdCount);

  assign req_ready_o = (state_q == S_IDLE) && !rsp_v_q;
  assign rsp_valid_o = rsp_v_q;
  assign rsp_o = rsp_q;

  // Neighbors of the current slot and the compare outcomes of a sift step.
  assign lchild = {slot_q, 1'b1};
  assign rchild = lchild + 1'b1;
  assign parent = SlotW'((slot_q - 1'b1) >> 1);
  assign up_move = (slot_q != '0) && (key_q < rd_q[IdW +: KeyW]);
  assign has_left = (32'(lchild) < 32'(size_q));
  assign pick_right = (32'(rchild) < 32'(size_q)) &&
                      (rd_q[IdW +: KeyW] < cl_q[IdW +: KeyW]);
  assign dn_elem = pick_right ? rd_q : cl_q;
  assign dn_slot = pick_right ? SlotW'(rchild) : SlotW'(lchild);
  assign dn_move = has_left && (dn_elem[IdW +: KeyW] < key_q);

  // Status of the request at the head of the front queue.
  always_comb begin
    acc_status = ST_OK;
    case (req_i.kind)
      KIND_INSERT: begin
        if (!id_ok) acc_status = ST_ABSENT;
        else if (idv_q[req_idx]) acc_status = ST_PRESENT;
        else if (size_q >= CapSize) acc_status = ST_FULL;
      end
      KIND_POP: begin
        if (size_q == '0) acc_status = ST_EMPTY;
      end
      KIND_REMOVE: begin
        if (!id_ok || !idv_q[req_idx]) acc_status = ST_ABSENT;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (hw_en) heap_mem[hw_addr] <= hw_data;
    rd_q <= heap_mem[hr_addr];
    if (pw_en) pos_mem[pw_addr] <= pw_data;
    pos_rd_q <= pos_mem[req_idx];
  end

  // Memory addresses and writes for each sequencer step.
  always_comb begin
    hw_en = 1'b0;
    hw_addr = slot_q;
    hw_data = {key_q, id_q};
    hr_addr = '0;
    pw_en = 1'b0;
    pw_addr = IdxW'(id_q);
    pw_data = slot_q;
    case (state_q)
      S_IDLE: hr_addr = SlotW'(size_q - 1'b1);
      S_UPRD: hr_addr = parent;
      S_UPCMP: begin
        if (up_move) begin
          hw_en = 1'b1;
          hw_data = rd_q;
          pw_en = 1'b1;
          pw_addr = IdxW'(rd_q[IdW-1:0]);
        end else if (moved_q) begin
          hw_en = 1'b1;
          pw_en = 1'b1;
        end
      end
      S_DNRD: hr_addr = SlotW'(lchild);
      S_DNL: hr_addr = SlotW'(rchild);
      S_DNCMP: begin
        if (dn_move) begin
          hw_en = 1'b1;
          hw_data = dn_elem;
          pw_en = 1'b1;
          pw_addr = IdxW'(dn_elem[IdW-1:0]);
        end else if (moved_q) begin
          hw_en = 1'b1;
          pw_en = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Sequencer for every request kind; sifts move one heap level per pass.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idv_q <= '0;
      size_q <= '0;
      rsp_v_q <= 1'b0;
    end else begin
      if (state_q == S_DONE) rsp_v_q <= 1'b1;
      else if (rsp_ready_i) rsp_v_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (req_valid_i && req_ready_o) begin
            req_q <= req_i;
            rsp_q <= '{status: acc_status, default: '0};
            // An insert always writes its entry at the slot where it stops.
            moved_q <= (req_i.kind == KIND_INSERT);
            if (acc_status != ST_OK) state_q <= S_FRONT;
            else begin
              case (req_i.kind)
                KIND_INSERT: begin
                  idv_q[req_idx] <= 1'b1;
                  slot_q <= SlotW'(size_q);
                  key_q <= req_i.wakeup_time;
                  id_q <= req_i.item_id;
                  size_q <= size_q + 1'b1;
                  state_q <= S_UPRD;
                end
                KIND_POP: begin
                  size_q <= size_q - 1'b1;
                  state_q <= S_LAST;
                end
                KIND_REMOVE: begin
                  idv_q[req_idx] <= 1'b0;
                  size_q <= size_q - 1'b1;
                  state_q <= S_LAST;
                end
                default: state_q <= S_FRONT;
              endcase
            end
          end
        end
        S_LAST: begin
          // rd_q holds the last element; pos_rd_q the hole for a remove.
          key_q <= rd_q[IdW +: KeyW];
          id_q <= rd_q[IdW-1:0];
          if (req_q.kind == KIND_POP) begin
            slot_q <= '0;
            state_q <= S_ROOT;
          end else begin
            slot_q <= pos_rd_q;
            if (32'(pos_rd_q) == 32'(size_q)) state_q <= S_FRONT;
            else state_q <= S_UPRD;
          end
        end
        S_ROOT: begin
          // Root read: the popped entry.
          rsp_q.popped_time <= rd_q[IdW +: KeyW];
          rsp_q.popped_id <= rd_q[IdW-1:0];
          if (IdCount >= 64 || 32'(rd_q[IdW-1:0]) < IdCount)
            idv_q[IdxW'(rd_q[IdW-1:0])] <= 1'b0;
          moved_q <= 1'b1;
          if (size_q == '0) state_q <= S_FRONT;
          else state_q <= S_DNRD;
        end
        S_UPRD: state_q <= S_UPCMP;
        S_UPCMP: begin
          if (up_move) begin
            slot_q <= parent;
            moved_q <= 1'b1;
            state_q <= S_UPRD;
          end else if (req_q.kind == KIND_REMOVE && !moved_q) begin
            // Hole element did not rise, so it is tried downward.
            moved_q <= 1'b1;
            state_q <= S_DNRD;
          end else state_q <= S_FRONT;
        end
        S_DNRD: state_q <= S_DNL;
        S_DNL: begin
          cl_q <= rd_q;
          state_q <= S_DNCMP;
        end
        S_DNCMP: begin
          if (dn_move) begin
            slot_q <= dn_slot;
            state_q <= S_DNRD;
          end else state_q <= S_FRONT;
        end
        // Root is read here after the last heap write.
        S_FRONT: state_q <= S_DONE;
        S_DONE: begin
          if (size_q != '0) begin
            rsp_q.front_valid <= 1'b1;
            rsp_q.front_time <= rd_q[IdW +: KeyW];
            rsp_q.front_id <= rd_q[IdW-1:0];
          end
          rsp_q.entry_count <= CountW'(size_q);
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- rtl/indexed_timer_min_heap_unit.sv -----
`default_nettype none
// Indexed timer min-heap: a sleep queue of (id, wakeup time) entries.
// Requests enter through push/full with kind_i, item_id_i and
// wakeup_time_i; kind selects insert, pop minimum, remove by id or a plain report.
// Every request yields one result, read through empty/pop: a status,
// the popped entry, the new front entry and the entry count.
// A two-entry request queue decouples the port from the heap sequencer,
// and a two-entry result queue decouples the sequencer from the reader.
// Errors and the unused kind go from the idle state straight to the
// S_FRONT state. Sifts pass S_UPRD and S_UPCMP per level upward and
// S_DNRD, S_DNL and S_DNCMP per level downward. One request is worked
// on at a time, so a new one starts only once the result of the last
// one has been handed to the result queue.
// Reset clears the queues, the entry count and all id presence bits;
// the heap storage needs no clearing.
// When the reader stalls, results collect in the result queue, then the
// sequencer waits and the request queue fills and raises full.
module indexed_timer_min_heap_unit import itmh_pkg::*; #(
  parameter int unsigned CAPACITY = CapacityDefault,
  parameter int unsigned ID_COUNT = IdCountDefault
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push,
  output logic                     full,
  input  wire logic [KindW-1:0]    kind_i,
  input  wire logic [IdW-1:0]      item_id_i,
  input  wire logic [KeyW-1:0]     wakeup_time_i,
  output logic                     empty,
  input  wire logic                pop,
  output logic [StatusW-1:0]       status_o,
  output logic [IdW-1:0]           popped_id_o,
  output logic [KeyW-1:0]          popped_time_o,
  output logic                     front_valid_o,
  output logic [IdW-1:0]           front_id_o,
  output logic [KeyW-1:0]          front_time_o,
  output logic [CountW-1:0]        entry_count_o
);
  req_t req_in, req_head;
  rsp_t rsp_c, rsp_out;
  logic req_empty, rsp_full, core_ready, core_valid;

  assign req_in = '{kind: kind_i, item_id: item_id_i, wakeup_time: wakeup_time_i};

  itmh_fifo #(.Width($bits(req_t))) u_req_q (
    .clk_i, .rst_ni, .push_i(push), .data_i(req_in), .full_o(full),
    .pop_i(core_ready), .data_o(req_head), .empty_o(req_empty)
  );

  itmh_core #(.Capacity(CAPACITY), .IdCount(ID_COUNT)) u_core (
    .clk_i, .rst_ni, .req_valid_i(!req_empty), .req_i(req_head),
    .req_ready_o(core_ready), .rsp_valid_o(core_valid), .rsp_o(rsp_c),
    .rsp_ready_i(!rsp_full)
  );

  itmh_fifo #(.Width($bits(rsp_t))) u_rsp_q (
    .clk_i, .rst_ni, .push_i(core_valid), .data_i(rsp_c), .full_o(rsp_full),
    .pop_i(pop), .data_o(rsp_out), .empty_o(empty)
  );

  assign status_o = rsp_out.status;
  assign popped_id_o = rsp_out.popped_id;
  assign popped_time_o = rsp_out.popped_time;
  assign front_valid_o = rsp_out.front_valid;
  assign front_id_o = rsp_out.front_id;
  assign front_time_o = rsp_out.front_time;
  assign entry_count_o = rsp_out.entry_count;

  // The front entry is reported exactly when the heap holds entries.
  a_front: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (front_valid_o == (entry_count_o != '0))) else $error("front mismatch");
  // A pop of an empty heap reports nothing popped.
  a_popz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o == ST_EMPTY) |-> (popped_id_o == '0 && entry_count_o == '0))
    else $error("empty pop result");
  // The entry count never exceeds the capacity.
  a_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (32'(entry_count_o) <= CAPACITY)) else $error("count overflow");
endmodule
`default_nettype wire
